// File: design/bsp_pkg.sv
// Shared types and constants for the bank-switched page mapper.
// Holds the transfer payload structs, the switch register layout and page codes.
// No dependencies.
package bsp_pkg;

  // Configuration register indexes, byte address is four times the index.
  localparam logic [1:0] RegBank   = 2'd0;
  localparam logic [1:0] RegCard   = 2'd1;
  localparam logic [1:0] RegShadow = 2'd2;

  localparam int unsigned AddrWidth = 4;

  localparam logic [5:0] BankSwitchesReset  = 6'd0;
  localparam logic [2:0] CardSwitchesReset  = 3'd0;
  localparam logic [6:0] ShadowSwitchesReset = 7'd109;

  localparam logic [15:0] AuxOffset  = 16'h0100;
  localparam logic [7:0]  RomBank    = 8'hFF;
  localparam logic [7:0]  PageIo     = 8'hC0;
  localparam logic [7:0]  PageCardHi = 8'hD0;
  localparam logic [7:0]  PageCardTop = 8'hE0;
  localparam logic [7:0]  PageCardShift = 8'h10;
  localparam logic [7:0]  BankE0     = 8'hE0;
  localparam logic [7:0]  BankE1     = 8'hE1;

  typedef struct packed {
    logic [15:0] page_number;
    logic        func;
  } in_item_t;

  typedef struct packed {
    logic [15:0] mapped_page;
    logic        is_io;
    logic        shadowed;
  } out_item_t;

  typedef struct packed {
    logic [5:0] bank_switches;
    logic [2:0] card_switches;
    logic [6:0] shadow_switches;
  } cfg_t;

endpackage

// File: design/bank_switched_page_mapper.sv
// Top level of the bank-switched page mapper: input and result registers.
// Depends on bsp_pkg, bsp_regs and bsp_xlate.
//
// Usage: each transfer on the input channel carries one bank:page number and
// a read/write selector. The block returns one transfer on the output channel
// with the translated bank:page, the I/O flag and the video shadow flag.
// Both channels use valid/ready; a transfer happens when both are high.
// The soft switches sit behind an APB-style port at byte addresses 0, 4
// and 8 (bank, card, shadow); pready is always high and writes land on the
// access cycle. Switches should only change while no transfer is in flight.
//
// From input transfer to output transfer, the item is captured in the input
// register, translated by a single pass of logic, and captured in the result
// register, where it is valid.
// Throughput is one item per cycle while the receiver does not stall; the
// translation between the two registers is combinational.
// When the receiver stalls, the result register holds its item and the
// input register holds the next one, so two items can wait before in_ready_o
// drops. Reset empties both stages and loads the switch reset values
// (bank 0, card 0, shadow 109).
module bank_switched_page_mapper (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  bsp_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output bsp_pkg::out_item_t            out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bsp_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  bsp_pkg::cfg_t      cfg;
  bsp_pkg::in_item_t  item_q;
  bsp_pkg::out_item_t result_d, result_q;
  logic               item_valid_q, result_valid_q;
  logic               result_load, item_load;

  bsp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bsp_xlate u_xlate (
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (result_d)
  );

  // The result register takes a new item whenever it is empty or being
  // drained this cycle; the input stage advances whenever it is empty or the result does.
  assign result_load = !result_valid_q || out_ready_i;
  assign in_ready_o  = !item_valid_q || result_load;
  assign item_load   = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q   <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        item_valid_q <= in_valid_i;
      end
      if (result_load) begin
        result_valid_q <= item_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_load) begin
      item_q <= in_data_i;
    end
    if (result_load && item_valid_q) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = result_valid_q;
  assign out_data_o  = result_q;

endmodule

// File: design/bsp_regs.sv
// APB-style register file holding the three soft-switch registers.
// Depends on bsp_pkg for the register indexes, reset values and cfg_t.
module bsp_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bsp_pkg::AddrWidth-1:0]     paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  output bsp_pkg::cfg_t                     cfg_o
);

  logic [5:0] bank_q;
  logic [2:0] card_q;
  logic [6:0] shadow_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q   <= bsp_pkg::BankSwitchesReset;
      card_q   <= bsp_pkg::CardSwitchesReset;
      shadow_q <= bsp_pkg::ShadowSwitchesReset;
    end else if (wr_en) begin
      if (reg_idx == bsp_pkg::RegBank) begin
        bank_q <= pwdata[5:0];
      end
      if (reg_idx == bsp_pkg::RegCard) begin
        card_q <= pwdata[2:0];
      end
      if (reg_idx == bsp_pkg::RegShadow) begin
        shadow_q <= pwdata[6:0];
      end
    end
  end

  // Reads of the unused index return zero.
  always_comb begin
    prdata = 32'd0;
    unique case (reg_idx)
      bsp_pkg::RegBank:   prdata = {26'd0, bank_q};
      bsp_pkg::RegCard:   prdata = {29'd0, card_q};
      bsp_pkg::RegShadow: prdata = {25'd0, shadow_q};
      default:            prdata = 32'd0;
    endcase
  end

  assign cfg_o.bank_switches   = bank_q;
  assign cfg_o.card_switches   = card_q;
  assign cfg_o.shadow_switches = shadow_q;

endmodule

// File: design/bsp_xlate.sv
// Page translation logic: main/aux, language card and video shadow rules.
// Purely combinational; depends on bsp_pkg for the payload and config types.
module bsp_xlate (
  input  bsp_pkg::in_item_t  item_i,
  input  bsp_pkg::cfg_t      cfg_i,
  output bsp_pkg::out_item_t result_o
);

  logic [7:0] bank;
  logic [7:0] pg;
  logic       wr;
  logic       store80, auxsel, altzp, page2, hires, lc;
  logic       card_en, card_bank, sel;
  logic [7:0] src;
  logic [15:0] mapped;
  logic       io;
  logic       text, text2, h1, h2, sup, aux;
  logic       shadow;

  assign bank    = item_i.page_number[15:8];
  assign pg      = item_i.page_number[7:0];
  assign wr      = item_i.func;
  assign store80 = cfg_i.bank_switches[0];
  assign auxsel  = wr ? cfg_i.bank_switches[2] : cfg_i.bank_switches[1];
  assign altzp   = cfg_i.bank_switches[3];
  assign page2   = cfg_i.bank_switches[4];
  assign hires   = cfg_i.bank_switches[5];
  assign lc      = cfg_i.shadow_switches[6];
  assign card_en = wr ? cfg_i.card_switches[2] : cfg_i.card_switches[1];
  assign card_bank = (bank == bsp_pkg::BankE0) || (bank == bsp_pkg::BankE1) ||
                     (((bank == 8'h00) || (bank == 8'h01)) && lc);
  assign src     = ((bank == 8'h00) && altzp) ? 8'h01 : bank;

  // Bank select for the low 48K of bank 00.
  always_comb begin
    priority if (pg < 8'h02) begin
      sel = altzp;
    end else if ((pg >= 8'h04) && (pg < 8'h08) && store80) begin
      sel = page2;
    end else if ((pg >= 8'h20) && (pg < 8'h40) && store80 && hires) begin
      sel = page2;
    end else begin
      sel = auxsel;
    end
  end

  always_comb begin
    mapped = item_i.page_number;
    io     = 1'b0;
    priority if ((bank == 8'h00) && (pg < bsp_pkg::PageIo)) begin
      if (sel) begin
        mapped = item_i.page_number + bsp_pkg::AuxOffset;
      end
    end else if ((pg >= bsp_pkg::PageIo) && card_bank) begin
      priority if (pg == bsp_pkg::PageIo) begin
        io = 1'b1;
      end else if ((pg < bsp_pkg::PageCardHi) || !card_en) begin
        mapped = {bsp_pkg::RomBank, pg};
      end else if (pg < bsp_pkg::PageCardTop) begin
        // Bank 1 of the card lies one 4K block below its window.
        mapped = cfg_i.card_switches[0] ? {src, pg} : {src, pg - bsp_pkg::PageCardShift};
      end else begin
        mapped = {src, pg};
      end
    end else if (bank == 8'h00) begin
      if (auxsel) begin
        mapped = item_i.page_number + bsp_pkg::AuxOffset;
      end
    end else begin
      mapped = item_i.page_number;
    end
  end

  assign text  = cfg_i.shadow_switches[0];
  assign text2 = cfg_i.shadow_switches[1];
  assign h1    = cfg_i.shadow_switches[2];
  assign h2    = cfg_i.shadow_switches[3];
  assign sup   = cfg_i.shadow_switches[4];
  assign aux   = cfg_i.shadow_switches[5];

  always_comb begin
    priority if (bank > 8'h01) begin
      shadow = 1'b0;
    end else if ((pg >= 8'h04) && (pg < 8'h08)) begin
      shadow = text;
    end else if ((pg >= 8'h08) && (pg < 8'h0C)) begin
      shadow = text2;
    end else if ((pg >= 8'h20) && (pg < 8'h40)) begin
      shadow = (bank == 8'h00) ? h1 : ((h1 && aux) || sup);
    end else if ((pg >= 8'h60) && (pg < 8'h80)) begin
      shadow = (bank == 8'h00) ? h2 : ((h2 && aux) || sup);
    end else begin
      shadow = 1'b0;
    end
  end

  assign result_o.mapped_page = mapped;
  assign result_o.is_io       = io;
  assign result_o.shadowed    = shadow;

endmodule
